FILE: hw/rtl/psve_pkg.sv
package psve_pkg;

   localparam int CordicSteps = 16;
   localparam int ZW = 34;   // residual angle width, units of 2^-32 turn
   localparam int XW = 34;   // CORDIC vector width (Q2.30 plus headroom)

   localparam logic signed [XW-1:0] CORDIC_K = 34'sd652032874;
   localparam logic signed [15:0] ONE_Q14 = 16'sd16384;
   localparam logic signed [15:0] INV_SQRT2_Q15 = 16'sd23170;
   localparam logic signed [15:0] INV_SQRT2_Q14 = 16'sd11585;
   localparam logic [15:0] ONE_Q15 = 16'd32768;

   typedef enum logic [1:0] {
      SHAPE_PLANE    = 2'd0,
      SHAPE_SPHERE   = 2'd1,
      SHAPE_CYLINDER = 2'd2,
      SHAPE_CONE     = 2'd3
   } shape_type;

   localparam logic [1:0] REG_SHAPE = 2'd0;

   // atan(2^-i) in units of 2^-32 turn
   function automatic logic signed [ZW-1:0] atan_turn(input logic [3:0] i);
      logic signed [ZW-1:0] r;
      unique case (i)
         4'd0:  r = 34'sh020000000;
         4'd1:  r = 34'sh012E4051E;
         4'd2:  r = 34'sh009FB385B;
         4'd3:  r = 34'sh0051111D4;
         4'd4:  r = 34'sh0028B0D43;
         4'd5:  r = 34'sh00145D7E1;
         4'd6:  r = 34'sh000A2F61E;
         4'd7:  r = 34'sh000517C55;
         4'd8:  r = 34'sh00028BE53;
         4'd9:  r = 34'sh000145F2F;
         4'd10: r = 34'sh0000A2F98;
         4'd11: r = 34'sh0000517CC;
         4'd12: r = 34'sh000028BE6;
         4'd13: r = 34'sh0000145F3;
         4'd14: r = 34'sh00000A2FA;
         default: r = 34'sh00000517D;
      endcase
      return r;
   endfunction

   // clamp a wide signed value to [-1, 1] in Q1.14
   function automatic logic signed [15:0] clamp_q14(input logic signed [47:0] a);
      logic signed [15:0] r;
      if (a > 48'sd16384) r = ONE_Q14;
      else if (a < -48'sd16384) r = -ONE_Q14;
      else r = a[15:0];
      return r;
   endfunction

endpackage

FILE: hw/rtl/psve_cordic.sv
// Pipelined rotation-mode CORDIC: 16-bit phase in, clamped Q1.14 cos/sin out.
// One phase per cycle; input register, micro-rotation stages, output register.
module psve_cordic (
   input  logic               clock,
   input  logic [15:0]        phase,
   output logic signed [15:0] cos_out,
   output logic signed [15:0] sin_out
);

   localparam int N = psve_pkg::CordicSteps;
   localparam int XW = psve_pkg::XW;
   localparam int ZW = psve_pkg::ZW;

   logic signed [XW-1:0] x_ff [N+1];
   logic signed [XW-1:0] y_ff [N+1];
   logic signed [ZW-1:0] z_ff [N+1];
   logic [1:0]           q_ff [N+1];
   logic signed [15:0]   cos_ff, sin_ff;

   // quadrant reduction
   logic [31:0] p_w, rd_w;
   logic [1:0]  q_w;
   always_comb begin
      p_w  = {phase, 16'd0};
      q_w  = 2'((p_w + 32'h2000_0000) >> 30);
      rd_w = p_w - {q_w, 30'd0};
   end

   always_ff @(posedge clock) begin
      x_ff[0] <= psve_pkg::CORDIC_K;
      y_ff[0] <= '0;
      z_ff[0] <= ZW'(signed'(rd_w));
      q_ff[0] <= q_w;
   end

   // one micro-rotation per stage
   for (genvar i = 0; i < N; i++) begin : g_stage
      always_ff @(posedge clock) begin
         if (!z_ff[i][ZW-1]) begin
            x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
            z_ff[i+1] <= z_ff[i] - psve_pkg::atan_turn(4'(i));
         end else begin
            x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
            z_ff[i+1] <= z_ff[i] + psve_pkg::atan_turn(4'(i));
         end
         q_ff[i+1] <= q_ff[i];
      end
   end

   // quadrant rotation, round and clamp
   logic signed [XW:0] c_w, s_w;
   always_comb begin
      unique case (q_ff[N])
         2'd0: begin c_w = (XW+1)'(x_ff[N]);  s_w = (XW+1)'(y_ff[N]);  end
         2'd1: begin c_w = -(XW+1)'(y_ff[N]); s_w = (XW+1)'(x_ff[N]);  end
         2'd2: begin c_w = -(XW+1)'(x_ff[N]); s_w = -(XW+1)'(y_ff[N]); end
         default: begin c_w = (XW+1)'(y_ff[N]); s_w = -(XW+1)'(x_ff[N]); end
      endcase
   end

   always_ff @(posedge clock) begin
      cos_ff <= psve_pkg::clamp_q14(48'((c_w + 35'sd32768) >>> 16));
      sin_ff <= psve_pkg::clamp_q14(48'((s_w + 35'sd32768) >>> 16));
   end

   assign cos_out = cos_ff;
   assign sin_out = sin_ff;

endmodule

FILE: hw/rtl/parametric_surface_vertex_eval.sv
// Parametric surface vertex evaluator. Each (u,v) pair taken on start gives
// one vertex (position, normal, texture coordinate) on rsp_valid; busy is
// always low, so a new pair may enter every cycle. The path: input stage,
// CORDIC input register, 16 rotation stages and rounding stage, product
// stage and output stage. The receiver cannot stall: results must be taken
// as they appear. surface_shape (0 plane, 1 sphere, 2 cylinder, 3 cone) is
// read at APB address 0 and must only change while no item is in flight.
module parametric_surface_vertex_eval (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [15:0]        req_u_coord,
   input  logic [15:0]        req_v_coord,
   output logic               rsp_valid,
   output logic signed [15:0] rsp_pos_x,
   output logic signed [15:0] rsp_pos_y,
   output logic signed [15:0] rsp_pos_z,
   output logic signed [15:0] rsp_norm_x,
   output logic signed [15:0] rsp_norm_y,
   output logic signed [15:0] rsp_norm_z,
   output logic [15:0]        rsp_tex_u,
   output logic [15:0]        rsp_tex_v,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [1:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   // stage 0 input reg, 1..18 CORDIC, 19 products, 20 output
   localparam int Lat = psve_pkg::CordicSteps + 5;

   // configuration register
   psve_pkg::shape_type shape_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         shape_ff <= psve_pkg::SHAPE_PLANE;
      end else if (psel && penable && pwrite && paddr == {psve_pkg::REG_SHAPE}) begin
         shape_ff <= psve_pkg::shape_type'(pwdata[1:0]);
      end
   end
   assign pready = 1'b1;
   assign prdata = (paddr == {psve_pkg::REG_SHAPE}) ? {30'd0, shape_ff} : 32'd0;
   assign busy = 1'b0;

   // stage 0: saturate inputs
   logic [15:0] u_ff, v_ff;
   logic [15:0] u_sat_w, v_sat_w;
   assign u_sat_w = (req_u_coord > psve_pkg::ONE_Q15) ? psve_pkg::ONE_Q15 : req_u_coord;
   assign v_sat_w = (req_v_coord > psve_pkg::ONE_Q15) ? psve_pkg::ONE_Q15 : req_v_coord;
   always_ff @(posedge clock) begin
      u_ff <= u_sat_w;
      v_ff <= v_sat_w;
   end

   // valid line and delayed u/v for the CORDIC latency
   localparam int Dly = psve_pkg::CordicSteps + 2;
   logic [Lat-1:0] vld_ff;
   logic [15:0] ud_ff [Dly];
   logic [15:0] vd_ff [Dly];
   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else vld_ff <= {vld_ff[Lat-2:0], start};
   end
   always_ff @(posedge clock) begin
      ud_ff[0] <= u_ff;
      vd_ff[0] <= v_ff;
      for (int i = 1; i < Dly; i++) begin
         ud_ff[i] <= ud_ff[i-1];
         vd_ff[i] <= vd_ff[i-1];
      end
   end

   logic signed [15:0] cu_w, su_w, cv_w, sv_w;
   psve_cordic u_cord_u (.clock(clock), .phase({u_ff[14:0], 1'b0}),
                         .cos_out(cu_w), .sin_out(su_w));
   psve_cordic u_cord_v (.clock(clock), .phase(v_ff),
                         .cos_out(cv_w), .sin_out(sv_w));

   // product stage: 16x16 (sphere) and 17x16 (cone) multiplies
   logic [15:0] ua_w, va_w;
   assign ua_w = ud_ff[Dly-1];
   assign va_w = vd_ff[Dly-1];
   logic signed [16:0] vs_w;
   assign vs_w = signed'({1'b0, va_w});

   logic signed [15:0] cu_ff, su_ff, cv_ff, hv_ff, u2_ff, v2_ff;
   logic signed [33:0] m0_ff, m1_ff, m2_ff, m3_ff;
   logic [15:0] tu_ff, tv_ff;
   always_ff @(posedge clock) begin
      cu_ff <= cu_w;
      su_ff <= su_w;
      cv_ff <= cv_w;
      m0_ff <= 34'(cu_w * sv_w);
      m1_ff <= 34'(su_w * sv_w);
      m2_ff <= 34'(vs_w * cu_w);
      m3_ff <= 34'(vs_w * su_w);
      hv_ff <= 16'((17'(va_w) + 17'd1) >> 1);
      u2_ff <= 16'((17'sd1 + signed'({1'b0, ua_w}) - 17'sd16384) >>> 1);
      v2_ff <= 16'((17'sd1 + vs_w - 17'sd16384) >>> 1);
      tu_ff <= ua_w;
      tv_ff <= va_w;
   end

   // cone normals: cos/sin times 1/sqrt2 Q0.15
   logic signed [33:0] nxc_w, nyc_w;
   assign nxc_w = 34'(cu_ff * psve_pkg::INV_SQRT2_Q15);
   assign nyc_w = 34'(su_ff * psve_pkg::INV_SQRT2_Q15);

   // output select
   logic signed [15:0] px_w, py_w, pz_w, nx_w, ny_w, nz_w;
   always_comb begin
      unique case (shape_ff)
         psve_pkg::SHAPE_PLANE: begin
            px_w = u2_ff; py_w = v2_ff; pz_w = '0;
            nx_w = '0; ny_w = '0; nz_w = psve_pkg::ONE_Q14;
         end
         psve_pkg::SHAPE_SPHERE: begin
            px_w = psve_pkg::clamp_q14(48'((m0_ff + 34'sd8192) >>> 14));
            py_w = psve_pkg::clamp_q14(48'((m1_ff + 34'sd8192) >>> 14));
            pz_w = cv_ff;
            nx_w = px_w; ny_w = py_w; nz_w = pz_w;
         end
         psve_pkg::SHAPE_CYLINDER: begin
            px_w = cu_ff; py_w = su_ff; pz_w = hv_ff;
            nx_w = cu_ff; ny_w = su_ff; nz_w = '0;
         end
         default: begin
            px_w = psve_pkg::clamp_q14(48'((m2_ff + 34'sd16384) >>> 15));
            py_w = psve_pkg::clamp_q14(48'((m3_ff + 34'sd16384) >>> 15));
            pz_w = hv_ff;
            nx_w = psve_pkg::clamp_q14(48'((nxc_w + 34'sd16384) >>> 15));
            ny_w = psve_pkg::clamp_q14(48'((nyc_w + 34'sd16384) >>> 15));
            nz_w = -psve_pkg::INV_SQRT2_Q14;
         end
      endcase
   end

   logic signed [15:0] px_ff, py_ff, pz_ff, nx_ff, ny_ff, nz_ff;
   logic [15:0] ou_ff, ov_ff;
   always_ff @(posedge clock) begin
      px_ff <= px_w; py_ff <= py_w; pz_ff <= pz_w;
      nx_ff <= nx_w; ny_ff <= ny_w; nz_ff <= nz_w;
      ou_ff <= tu_ff; ov_ff <= tv_ff;
   end

   assign rsp_valid  = vld_ff[Lat-1];
   assign rsp_pos_x  = px_ff;
   assign rsp_pos_y  = py_ff;
   assign rsp_pos_z  = pz_ff;
   assign rsp_norm_x = nx_ff;
   assign rsp_norm_y = ny_ff;
   assign rsp_norm_z = nz_ff;
   assign rsp_tex_u  = ou_ff;
   assign rsp_tex_v  = ov_ff;

   // checks
   a_busy_low: assert property (@(posedge clock) !busy)
      else $error("busy raised");
   a_tex_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_tex_u <= psve_pkg::ONE_Q15 && rsp_tex_v <= psve_pkg::ONE_Q15))
      else $error("texture coordinate out of range");
   a_norm_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_norm_z <= psve_pkg::ONE_Q14 && rsp_norm_z >= -psve_pkg::ONE_Q14))
      else $error("normal z out of range");

endmodule
